// ===== rtl/vdbc_pkg.sv =====
// ----------------------------------------------------------------------------
// Vehicle drive and body control package
// Shared payload types, register indexes, command and output codes.
// ----------------------------------------------------------------------------
`default_nettype none

package vdbc_pkg;

    // Widths fixed by the field definitions.
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 8;
    localparam int ACK_W      = 4;
    localparam int STARTUP_W  = 8;
    localparam int PROD_W     = 15;

    // Default values of the module parameters.
    localparam int ACK_TICKS_DEF     = 8;
    localparam int BLINK_COUNT_DEF   = 3;
    localparam int STARTUP_TICKS_DEF = 60;

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] REG_TRIM_DEFAULT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIM_MIN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TRIM_MAX     = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DEFAULT = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_MIN     = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_MAX     = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_GAIN_DIVISOR = 3'd6;

    // Configuration reset values.
    localparam logic signed [6:0] TRIM_DEFAULT_RST = 7'sd0;
    localparam logic signed [6:0] TRIM_MIN_RST     = -7'sd16;
    localparam logic signed [6:0] TRIM_MAX_RST     = 7'sd16;
    localparam logic [7:0]        GAIN_DEFAULT_RST = 8'd10;
    localparam logic [7:0]        GAIN_MIN_RST     = 8'd1;
    localparam logic [7:0]        GAIN_MAX_RST     = 8'd20;
    localparam logic [7:0]        GAIN_DIVISOR_RST = 8'd10;

    // Tick kinds.
    localparam logic ACT_DRIVE = 1'b0;
    localparam logic ACT_BODY  = 1'b1;

    // Trim and gain commands.
    localparam logic [1:0] CMD_NONE    = 2'd0;
    localparam logic [1:0] CMD_INIT    = 2'd1;
    localparam logic [1:0] STEER_RIGHT = 2'd2;
    localparam logic [1:0] STEER_LEFT  = 2'd3;
    localparam logic [1:0] GAIN_UP     = 2'd2;
    localparam logic [1:0] GAIN_DOWN   = 2'd3;

    // Turn signal codes.
    localparam logic [2:0] TURN_OFF         = 3'd0;
    localparam logic [2:0] TURN_BOTH_ON     = 3'd1;
    localparam logic [2:0] TURN_RIGHT_ON    = 3'd2;
    localparam logic [2:0] TURN_LEFT_ON     = 3'd3;
    localparam logic [2:0] TURN_BOTH_BLINK  = 3'd4;
    localparam logic [2:0] TURN_RIGHT_BLINK = 3'd5;
    localparam logic [2:0] TURN_LEFT_BLINK  = 3'd6;
    localparam logic [2:0] TURN_UNUSED      = 3'd7;

    // Buzzer codes.
    localparam logic [1:0] BUZZ_OFF    = 2'd0;
    localparam logic [1:0] BUZZ_ON     = 2'd1;
    localparam logic [1:0] BUZZ_BEEP   = 2'd2;
    localparam logic [1:0] BUZZ_UNUSED = 2'd3;

    typedef struct packed {
        logic              action;
        logic signed [7:0] angle_in;
        logic signed [7:0] speed_in;
        logic              brake_in;
        logic [1:0]        steer_cmd;
        logic [1:0]        gain_cmd;
        logic              head_switch;
        logic              fog_switch;
        logic              hazard_switch;
        logic              right_switch;
        logic              left_switch;
    } t_vdbc_in;

    typedef struct packed {
        logic signed [7:0] steer_out;
        logic signed [7:0] speed_out;
        logic              brake_out;
        logic              head_lamp;
        logic              fog_lamp;
        logic              brake_lamp;
        logic              back_lamp;
        logic [2:0]        turn_signal;
        logic [1:0]        buzzer;
    } t_vdbc_out;

endpackage

`default_nettype wire

// ===== rtl/vehicle_drive_and_body_control.sv =====
// ----------------------------------------------------------------------------
// Vehicle drive and body control
// Steering trim, scaled speed and brake for drive ticks; lamps, turn signal
// and buzzer for body ticks, with a start-up blink phase.
// ----------------------------------------------------------------------------
//
// Usage notes.
// The input channel (i_in_valid / o_in_stall / i_in_data) carries one tick per
// transaction, either a drive tick or a body tick. Every tick produces exactly
// one result transaction on the output channel (o_out_valid / i_out_stall /
// o_out_data) that carries all held output fields.
// A drive tick runs a bit-serial shift-add multiply of |speed| by the gain
// and a restoring divide by the divisor, one quotient bit per cycle, in the
// states S_MUL and S_DIV; then S_DONE hands its result to the output
// register, and o_in_stall holds off the next tick until then. A body tick is
// settled in the acceptance cycle; its result goes through r_held and S_DONE
// into the output register, and the next tick waits until S_DONE is left.
// The result sits in an output register. If the receiver stalls, a finished
// result waits there while the next tick is accepted and worked on; the block
// only holds off a new result, and then new input, until that register drains.
// Configuration writes (i_cfg_we / i_cfg_addr / i_cfg_wdata) are to be made
// while the block is idle; the block does not enforce this. Synchronous low
// i_rst_n resets all registers but r_out and the serial datapath, reloads
// trim and gain, empties the output register, restarts the start-up blink.
// ----------------------------------------------------------------------------
`default_nettype none

module vehicle_drive_and_body_control #(
    parameter int ACK_TICKS     = vdbc_pkg::ACK_TICKS_DEF,
    parameter int BLINK_COUNT   = vdbc_pkg::BLINK_COUNT_DEF,
    parameter int STARTUP_TICKS = vdbc_pkg::STARTUP_TICKS_DEF
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // Input transactions
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  vdbc_pkg::t_vdbc_in            i_in_data,
    // Output transactions
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output vdbc_pkg::t_vdbc_out                 o_out_data,
    // Configuration writes
    input  wire                                 i_cfg_we,
    input  wire  [vdbc_pkg::CFG_ADDR_W-1:0]     i_cfg_addr,
    input  wire  [vdbc_pkg::CFG_DATA_W-1:0]     i_cfg_wdata
);

    import vdbc_pkg::*;

    // The start-up blink toggles every BLINK_PERIOD body ticks.
    localparam int BLINK_RAW    = STARTUP_TICKS / (BLINK_COUNT * 2);
    localparam int BLINK_PERIOD = (BLINK_RAW == 0) ? 1 : BLINK_RAW;
    localparam int BLINK_W      = (BLINK_PERIOD > 1) ? $clog2(BLINK_PERIOD) : 1;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_MUL  = 2'd1;
    localparam logic [1:0] S_DIV  = 2'd2;
    localparam logic [1:0] S_DONE = 2'd3;

    localparam logic [3:0] MUL_LAST = 4'd7;
    localparam logic [3:0] DIV_LAST = 4'(PROD_W - 1);

    // Control state
    logic [1:0]             r_state;
    logic [3:0]             r_cnt;
    logic                   r_out_valid;
    t_vdbc_out              r_out;
    t_vdbc_out              r_held;

    // Configuration registers
    logic signed [6:0]      r_trim_default, r_trim_min, r_trim_max;
    logic [7:0]             r_gain_default, r_gain_min, r_gain_max, r_gain_divisor;

    // Block state
    logic signed [6:0]      r_trim;
    logic [7:0]             r_gain;
    logic [ACK_W-1:0]       r_ack_both, r_ack_right, r_ack_left;
    logic                   r_last_neg;
    logic                   r_last_brake;
    logic [STARTUP_W-1:0]   r_startup_cnt;
    logic [BLINK_W-1:0]     r_blink_cnt;
    logic                   r_blink_odd;
    logic [4:0]             r_toggle;
    logic [4:0]             r_prev_sw;

    // Serial datapath
    logic [7:0]             r_mul;
    logic [PROD_W-1:0]      r_acc;
    logic [7:0]             r_rem;
    logic                   r_neg;

    logic                   in_fire;
    logic                   out_free;

    assign o_in_stall  = (r_state != S_IDLE);
    assign in_fire     = i_in_valid && !o_in_stall;
    assign out_free    = !r_out_valid || !i_out_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // ------------------------------------------------------------------
    // Drive tick: trim and gain commands, acknowledge loads, steering sum.
    // ------------------------------------------------------------------
    logic signed [6:0]  n_trim;
    logic [7:0]         n_gain;
    logic [ACK_W-1:0]   n_drv_both, n_drv_right, n_drv_left;
    logic signed [8:0]  steer_sum;
    logic signed [7:0]  steer_sat;
    logic [7:0]         speed_abs;

    always_comb begin
        n_trim = r_trim;
        case (i_in_data.steer_cmd)
            CMD_INIT: begin
                n_trim = r_trim_default;
            end
            STEER_RIGHT: begin
                if (r_trim > r_trim_min) n_trim = r_trim - 7'sd1;
            end
            STEER_LEFT: begin
                if (r_trim < r_trim_max) n_trim = r_trim + 7'sd1;
            end
            default: begin
                n_trim = r_trim;
            end
        endcase

        n_gain = r_gain;
        case (i_in_data.gain_cmd)
            CMD_INIT: begin
                n_gain = r_gain_default;
            end
            GAIN_UP: begin
                if (r_gain < r_gain_max) n_gain = r_gain + 8'd1;
            end
            GAIN_DOWN: begin
                if (r_gain > r_gain_min) n_gain = r_gain - 8'd1;
            end
            default: begin
                n_gain = r_gain;
            end
        endcase

        // Any command other than none restarts an acknowledge countdown.
        n_drv_both  = r_ack_both;
        n_drv_right = r_ack_right;
        n_drv_left  = r_ack_left;
        if (i_in_data.steer_cmd == CMD_INIT || i_in_data.gain_cmd == CMD_INIT)
            n_drv_both = ACK_W'(ACK_TICKS);
        if (i_in_data.steer_cmd == STEER_RIGHT || i_in_data.gain_cmd == GAIN_UP)
            n_drv_right = ACK_W'(ACK_TICKS);
        if (i_in_data.steer_cmd == STEER_LEFT || i_in_data.gain_cmd == GAIN_DOWN)
            n_drv_left = ACK_W'(ACK_TICKS);

        steer_sum = 9'(i_in_data.angle_in) + 9'(n_trim);
        if (steer_sum > 9'sd127)
            steer_sat = 8'sd127;
        else if (steer_sum < -9'sd128)
            steer_sat = -8'sd128;
        else
            steer_sat = steer_sum[7:0];

        // Magnitude of the speed; the most negative code maps to 128.
        speed_abs = i_in_data.speed_in[7] ? 8'(-i_in_data.speed_in)
                                          : i_in_data.speed_in;
    end

    // ------------------------------------------------------------------
    // Body tick: start-up blink or switch latches, lamps and turn signal.
    // ------------------------------------------------------------------
    logic [4:0]            sw;
    logic [4:0]            n_toggle;
    logic [ACK_W-1:0]      n_body_both, n_body_right, n_body_left;
    logic [STARTUP_W-1:0]  n_startup_cnt;
    logic [BLINK_W-1:0]    n_blink_cnt;
    logic                  n_blink_odd;
    t_vdbc_out             n_body;

    assign sw = {i_in_data.left_switch, i_in_data.right_switch,
                 i_in_data.hazard_switch, i_in_data.fog_switch,
                 i_in_data.head_switch};

    always_comb begin
        n_toggle      = r_toggle;
        n_body_both   = r_ack_both;
        n_body_right  = r_ack_right;
        n_body_left   = r_ack_left;
        n_startup_cnt = r_startup_cnt;
        n_blink_cnt   = r_blink_cnt;
        n_blink_odd   = r_blink_odd;
        n_body        = r_held;

        if (r_startup_cnt <= STARTUP_W'(STARTUP_TICKS)) begin
            // Start-up phase: everything on in even blink periods.
            n_body.head_lamp   = !r_blink_odd;
            n_body.fog_lamp    = !r_blink_odd;
            n_body.brake_lamp  = !r_blink_odd;
            n_body.back_lamp   = !r_blink_odd;
            n_body.turn_signal = r_blink_odd ? TURN_OFF : TURN_BOTH_ON;
            n_body.buzzer      = r_blink_odd ? BUZZ_OFF : BUZZ_ON;
            n_startup_cnt      = r_startup_cnt + STARTUP_W'(1);
            if (r_blink_cnt == BLINK_W'(BLINK_PERIOD - 1)) begin
                n_blink_cnt = '0;
                n_blink_odd = !r_blink_odd;
            end else begin
                n_blink_cnt = r_blink_cnt + BLINK_W'(1);
            end
        end else begin
            n_toggle = r_toggle ^ (sw & ~r_prev_sw);

            n_body.head_lamp  = n_toggle[0];
            n_body.fog_lamp   = n_toggle[1];
            n_body.brake_lamp = r_last_brake;
            n_body.back_lamp  = r_last_neg;
            n_body.buzzer     = r_last_neg ? BUZZ_BEEP : BUZZ_OFF;

            if (r_ack_both != '0 || r_ack_right != '0 || r_ack_left != '0) begin
                // Countdowns run in the order both, right, left; the last one
                // that is still running decides the code.
                if (r_ack_both != '0) begin
                    n_body_both = r_ack_both - ACK_W'(1);
                    n_body.turn_signal = (n_body_both == '0) ? TURN_OFF : TURN_BOTH_ON;
                end
                if (r_ack_right != '0) begin
                    n_body_right = r_ack_right - ACK_W'(1);
                    n_body.turn_signal = (n_body_right == '0) ? TURN_OFF : TURN_RIGHT_ON;
                end
                if (r_ack_left != '0) begin
                    n_body_left = r_ack_left - ACK_W'(1);
                    n_body.turn_signal = (n_body_left == '0) ? TURN_OFF : TURN_LEFT_ON;
                end
            end else if (n_toggle[2] || (n_toggle[3] && n_toggle[4])) begin
                n_body.turn_signal = TURN_BOTH_BLINK;
            end else if (n_toggle[3]) begin
                n_body.turn_signal = TURN_RIGHT_BLINK;
            end else if (n_toggle[4]) begin
                n_body.turn_signal = TURN_LEFT_BLINK;
            end else begin
                n_body.turn_signal = TURN_OFF;
            end
        end
    end

    // ------------------------------------------------------------------
    // Serial multiply and divide steps.
    // ------------------------------------------------------------------
    logic [7:0]         div_eff;
    logic [PROD_W-1:0]  n_mul_acc;
    logic [8:0]         rem_sh;
    logic               q_bit;
    logic [7:0]         n_rem;
    logic [PROD_W-1:0]  n_div_acc;
    logic signed [7:0]  speed_sat;

    always_comb begin
        div_eff = (r_gain_divisor == 8'd0) ? 8'd1 : r_gain_divisor;

        // Shift-add, most significant multiplier bit first.
        n_mul_acc = {r_acc[PROD_W-2:0], 1'b0} + (r_mul[7] ? PROD_W'(r_gain) : '0);

        // Restoring divide; the dividend shifts out as quotient bits shift in.
        rem_sh    = {r_rem, r_acc[PROD_W-1]};
        q_bit     = (rem_sh >= {1'b0, div_eff});
        n_rem     = q_bit ? 8'(rem_sh - {1'b0, div_eff}) : rem_sh[7:0];
        n_div_acc = {r_acc[PROD_W-2:0], q_bit};

        // Quotient magnitude back to a signed, saturated byte.
        if (r_neg)
            speed_sat = (n_div_acc > PROD_W'(128)) ? -8'sd128 : 8'(-n_div_acc);
        else
            speed_sat = (n_div_acc > PROD_W'(127)) ? 8'sd127 : n_div_acc[7:0];
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_cnt          <= '0;
            r_out_valid    <= 1'b0;
            r_held         <= '0;
            r_trim_default <= TRIM_DEFAULT_RST;
            r_trim_min     <= TRIM_MIN_RST;
            r_trim_max     <= TRIM_MAX_RST;
            r_gain_default <= GAIN_DEFAULT_RST;
            r_gain_min     <= GAIN_MIN_RST;
            r_gain_max     <= GAIN_MAX_RST;
            r_gain_divisor <= GAIN_DIVISOR_RST;
            r_trim         <= TRIM_DEFAULT_RST;
            r_gain         <= GAIN_DEFAULT_RST;
            r_ack_both     <= '0;
            r_ack_right    <= '0;
            r_ack_left     <= '0;
            r_last_neg     <= 1'b0;
            r_last_brake   <= 1'b0;
            r_startup_cnt  <= '0;
            r_blink_cnt    <= '0;
            r_blink_odd    <= 1'b0;
            r_toggle       <= '0;
            r_prev_sw      <= '0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_addr)
                    REG_TRIM_DEFAULT: r_trim_default <= i_cfg_wdata[6:0];
                    REG_TRIM_MIN:     r_trim_min     <= i_cfg_wdata[6:0];
                    REG_TRIM_MAX:     r_trim_max     <= i_cfg_wdata[6:0];
                    REG_GAIN_DEFAULT: r_gain_default <= i_cfg_wdata;
                    REG_GAIN_MIN:     r_gain_min     <= i_cfg_wdata;
                    REG_GAIN_MAX:     r_gain_max     <= i_cfg_wdata;
                    REG_GAIN_DIVISOR: r_gain_divisor <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end

            // The output register takes a finished tick, or empties when taken.
            if (r_state == S_DONE && out_free)
                r_out_valid <= 1'b1;
            else if (r_out_valid && !i_out_stall)
                r_out_valid <= 1'b0;

            case (r_state)
                S_IDLE: begin
                    if (in_fire) begin
                        if (i_in_data.action == ACT_DRIVE) begin
                            r_trim                <= n_trim;
                            r_gain                <= n_gain;
                            r_ack_both            <= n_drv_both;
                            r_ack_right           <= n_drv_right;
                            r_ack_left            <= n_drv_left;
                            r_held.steer_out      <= steer_sat;
                            r_held.brake_out      <= i_in_data.brake_in;
                            r_last_neg            <= i_in_data.speed_in[7];
                            r_last_brake          <= i_in_data.brake_in;
                            r_mul                 <= speed_abs;
                            r_neg                 <= i_in_data.speed_in[7];
                            r_acc                 <= '0;
                            r_cnt                 <= '0;
                            r_state               <= S_MUL;
                        end else begin
                            r_held                <= n_body;
                            r_toggle              <= n_toggle;
                            r_prev_sw             <= (r_startup_cnt <=
                                                      STARTUP_W'(STARTUP_TICKS))
                                                     ? r_prev_sw : sw;
                            r_ack_both            <= n_body_both;
                            r_ack_right           <= n_body_right;
                            r_ack_left            <= n_body_left;
                            r_startup_cnt         <= n_startup_cnt;
                            r_blink_cnt           <= n_blink_cnt;
                            r_blink_odd           <= n_blink_odd;
                            r_state               <= S_DONE;
                        end
                    end
                end
                S_MUL: begin
                    r_acc <= n_mul_acc;
                    r_mul <= {r_mul[6:0], 1'b0};
                    if (r_cnt == MUL_LAST) begin
                        r_cnt   <= '0;
                        r_rem   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DIV: begin
                    r_acc <= n_div_acc;
                    r_rem <= n_rem;
                    if (r_cnt == DIV_LAST) begin
                        r_held.speed_out <= speed_sat;
                        r_state          <= S_DONE;
                    end else begin
                        r_cnt <= r_cnt + 4'd1;
                    end
                end
                S_DONE: begin
                    // Hand the held fields to the output register once it drains.
                    if (out_free) begin
                        r_out       <= r_held;
                        r_state     <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

`default_nettype wire

// ===== rtl/vdbc_checker.sv =====
// ----------------------------------------------------------------------------
// Vehicle drive and body control checker
// Port-level checks of the handshakes and result codes, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module vdbc_checker (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_in_stall,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire vdbc_pkg::t_vdbc_out o_out_data
);

    import vdbc_pkg::*;

    // Reset empties the output register and leaves the block ready.
    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (!o_out_valid && !o_in_stall))
        else $error("output valid or input stall after reset");

    a_valid_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> o_out_valid)
        else $error("result transaction dropped while stalled");

    a_data_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=> $stable(o_out_data))
        else $error("result payload changed while stalled");

    // A result only appears once its tick is finished, so input is open again.
    a_ready_on_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !o_in_stall)
        else $error("new result while a tick is still being worked on");

    a_codes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.turn_signal != TURN_UNUSED &&
                         o_out_data.buzzer != BUZZ_UNUSED))
        else $error("turn signal or buzzer code out of range");

endmodule

bind vehicle_drive_and_body_control vdbc_checker u_vdbc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

`default_nettype wire
